/* rtl/core/stc_pkg.sv */
`default_nettype none

package stc_pkg;

    // digit width of the partial-product multipliers
    localparam int DIGIT_W = 32;

    // radius register and its square
    localparam int RADIUS_W = 31;
    localparam int R2_W     = 2 * RADIUS_W;

    // register stages from input transfer to the output buffer
    localparam int PIPE_STAGES = 10;

    // per-edge decisions carried alongside the wide products
    typedef struct packed {
        logic le0;   // projection parameter at or before the start vertex
        logic gedd;  // projection parameter at or beyond the end vertex
        logic hs;    // start vertex within radius
        logic he;    // end vertex within radius
    } seg_flags_t;

    typedef struct packed {
        logic collides;
        logic inside_prism;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/stc_delay.sv */
`default_nettype none

module stc_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] tap_reg [N];

    // enabled shift line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int s = 1; s < N; s++)
            begin
                tap_reg[s] <= tap_reg[s-1];
            end
        end
    end

    assign q = tap_reg[N-1];

endmodule

`default_nettype wire

/* rtl/core/stc_mul.sv */
`default_nettype none

// Signed multiplier in three stages: digit products, row sums, final sum.
module stc_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0]   p
);

    localparam int DG  = stc_pkg::DIGIT_W;
    localparam int NA  = (AW + DG - 1) / DG;
    localparam int NB  = (BW + DG - 1) / DG;
    localparam int PW  = AW + BW;
    localparam int PPW = 2 * DG + 2;

    logic signed [NA*DG-1:0] a_ext;
    logic signed [NB*DG-1:0] b_ext;
    logic signed [DG:0]      da [NA];
    logic signed [DG:0]      db [NB];
    logic signed [PPW-1:0]   pp_reg [NA][NB];
    logic signed [PW-1:0]    row_next [NA];
    logic signed [PW-1:0]    row_reg [NA];
    logic signed [PW-1:0]    p_next;
    logic signed [PW-1:0]    p_reg;

    assign a_ext = (NA*DG)'(a);
    assign b_ext = (NB*DG)'(b);

    // low digits unsigned, top digit carries the sign
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            if (i == NA - 1)
                da[i] = (DG+1)'($signed(a_ext[i*DG +: DG]));
            else
                da[i] = $signed({1'b0, a_ext[i*DG +: DG]});
        end
        for (int j = 0; j < NB; j++)
        begin
            if (j == NB - 1)
                db[j] = (DG+1)'($signed(b_ext[j*DG +: DG]));
            else
                db[j] = $signed({1'b0, b_ext[j*DG +: DG]});
        end
    end

    // stage 1: digit products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= da[i] * db[j];
                end
            end
        end
    end

    // stage 2: one row per digit of a
    always_comb
    begin
        logic signed [PW-1:0] acc;
        for (int i = 0; i < NA; i++)
        begin
            acc = '0;
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (PW'(pp_reg[i][j]) <<< (DG * j));
            end
            row_next[i] = acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg <= row_next;
        end
    end

    // stage 3: rows shifted into place
    always_comb
    begin
        logic signed [PW-1:0] acc;
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            acc = acc + (row_reg[i] <<< (DG * i));
        end
        p_next = acc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* rtl/core/stc_front.sv */
`default_nettype none

// Edge vectors, then cross products and short dot products.
module stc_front #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [COORD_BITS-1:0]  va [3],
    input  wire logic signed [COORD_BITS-1:0]  vb [3],
    input  wire logic signed [COORD_BITS-1:0]  vc [3],
    input  wire logic signed [COORD_BITS-1:0]  vq [3],
    output logic signed [2*COORD_BITS+2:0]     n_out [3],
    output logic signed [2*COORD_BITS+2:0]     cr_out [3][3],
    output logic signed [2*COORD_BITS+3:0]     t_out [3],
    output logic signed [2*COORD_BITS+3:0]     dd_out [3],
    output logic signed [2*COORD_BITS+3:0]     ww_out [3],
    output logic signed [COORD_BITS:0]         qa_out [3]
);

    localparam int DW  = COORD_BITS + 1;
    localparam int XW  = 2 * DW + 1;
    localparam int DTW = 2 * DW + 2;

    // edge k runs from its start vertex along d; w is centre minus start
    logic signed [DW-1:0]  d_reg [3][3];
    logic signed [DW-1:0]  w_reg [3][3];
    logic signed [DW-1:0]  ac_reg [3];
    logic signed [XW-1:0]  n_reg [3];
    logic signed [XW-1:0]  cr_reg [3][3];
    logic signed [DTW-1:0] t_reg [3];
    logic signed [DTW-1:0] dd_reg [3];
    logic signed [DTW-1:0] ww_reg [3];
    logic signed [DW-1:0]  qa_reg [3];

    function automatic logic signed [XW-1:0] cross_c(
        input logic signed [DW-1:0] u [3],
        input logic signed [DW-1:0] v [3],
        input int                   i
    );
        int j;
        int k;
        logic signed [2*DW-1:0] p1;
        logic signed [2*DW-1:0] p2;
        j  = (i == 2) ? 0 : i + 1;
        k  = (j == 2) ? 0 : j + 1;
        p1 = u[j] * v[k];
        p2 = u[k] * v[j];
        return XW'(p1) - XW'(p2);
    endfunction

    function automatic logic signed [DTW-1:0] dot3(
        input logic signed [DW-1:0] u [3],
        input logic signed [DW-1:0] v [3]
    );
        logic signed [2*DW-1:0] p0;
        logic signed [2*DW-1:0] p1;
        logic signed [2*DW-1:0] p2;
        p0 = u[0] * v[0];
        p1 = u[1] * v[1];
        p2 = u[2] * v[2];
        return DTW'(p0) + DTW'(p1) + DTW'(p2);
    endfunction

    // stage 1: differences (edges AB, BC, CA, the AC side and centre offsets)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[0][i] <= DW'(vb[i]) - DW'(va[i]);
                d_reg[1][i] <= DW'(vc[i]) - DW'(vb[i]);
                d_reg[2][i] <= DW'(va[i]) - DW'(vc[i]);
                w_reg[0][i] <= DW'(vq[i]) - DW'(va[i]);
                w_reg[1][i] <= DW'(vq[i]) - DW'(vb[i]);
                w_reg[2][i] <= DW'(vq[i]) - DW'(vc[i]);
                ac_reg[i]   <= DW'(vc[i]) - DW'(va[i]);
            end
        end
    end

    // stage 2: normal, edge x offset, and segment dot products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i]  <= cross_c(d_reg[0], ac_reg, i);
                qa_reg[i] <= w_reg[0][i];
            end
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cr_reg[k][i] <= cross_c(d_reg[k], w_reg[k], i);
                end
                t_reg[k]  <= dot3(w_reg[k], d_reg[k]);
                dd_reg[k] <= dot3(d_reg[k], d_reg[k]);
                ww_reg[k] <= dot3(w_reg[k], w_reg[k]);
            end
        end
    end

    assign n_out  = n_reg;
    assign cr_out = cr_reg;
    assign t_out  = t_reg;
    assign dd_out = dd_reg;
    assign ww_out = ww_reg;
    assign qa_out = qa_reg;

endmodule

`default_nettype wire

/* rtl/core/sphere_triangle_collision_top.sv */
// Sphere against triangle contact test, fully pipelined.
// Ten register stages from input to output buffer: differences, cross and dot
//   products, two three-stage multipliers with sums between, final decision.
// One triangle per cycle unless in_stall; a two-entry buffer absorbs stalls.
// Reset: rst_n asynchronous, clears valid bits, buffer count and the radius.
`default_nettype none

module sphere_triangle_collision_top #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [stc_pkg::RADIUS_W-1:0]         sphere_radius,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [COORD_BITS-1:0]         vertex_a_x,
    input  wire logic signed [COORD_BITS-1:0]         vertex_a_y,
    input  wire logic signed [COORD_BITS-1:0]         vertex_a_z,
    input  wire logic signed [COORD_BITS-1:0]         vertex_b_x,
    input  wire logic signed [COORD_BITS-1:0]         vertex_b_y,
    input  wire logic signed [COORD_BITS-1:0]         vertex_b_z,
    input  wire logic signed [COORD_BITS-1:0]         vertex_c_x,
    input  wire logic signed [COORD_BITS-1:0]         vertex_c_y,
    input  wire logic signed [COORD_BITS-1:0]         vertex_c_z,
    input  wire logic signed [COORD_BITS-1:0]         center_x,
    input  wire logic signed [COORD_BITS-1:0]         center_y,
    input  wire logic signed [COORD_BITS-1:0]         center_z,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      collides,
    output logic                                      inside_prism
);

    localparam int NS    = stc_pkg::PIPE_STAGES;
    localparam int DW    = COORD_BITS + 1;
    localparam int XW    = 2 * DW + 1;
    localparam int DTW   = 2 * DW + 2;
    localparam int TW    = 2 * XW + 2;
    localparam int PDW   = XW + DW + 2;
    localparam int R2SW  = stc_pkg::R2_W + 1;
    localparam int FW    = ((DTW > R2SW) ? DTW : R2SW) + 1;
    localparam int SW    = ((2*DTW + 1 > R2SW + DTW) ? 2*DTW + 1 : R2SW + DTW) + 1;
    localparam int CMPW  = ((2*PDW > R2SW + TW) ? 2*PDW : R2SW + TW) + 1;

    // radius register and its square
    logic [stc_pkg::RADIUS_W-1:0] radius_reg;
    logic [stc_pkg::R2_W-1:0]     r2_reg;
    logic signed [R2SW-1:0]       r2s;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            r2_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                radius_reg <= sphere_radius;
            end
            r2_reg <= radius_reg * radius_reg;
        end
    end

    assign r2s = $signed({1'b0, r2_reg});

    // pipeline advance and valid bits
    logic          adv;
    logic          push;
    logic          pop;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic [NS-1:0] v_reg;

    assign pop      = out_valid && !out_stall;
    assign adv      = (count_reg != 2'd2) || pop;
    assign in_stall = !adv;
    assign push     = adv && v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    // stages 1-2
    logic signed [COORD_BITS-1:0] va [3];
    logic signed [COORD_BITS-1:0] vb [3];
    logic signed [COORD_BITS-1:0] vc [3];
    logic signed [COORD_BITS-1:0] vq [3];
    logic signed [XW-1:0]         n_s2 [3];
    logic signed [XW-1:0]         cr_s2 [3][3];
    logic signed [DTW-1:0]        t_s2 [3];
    logic signed [DTW-1:0]        dd_s2 [3];
    logic signed [DTW-1:0]        ww_s2 [3];
    logic signed [DW-1:0]         qa_s2 [3];

    assign va[0] = vertex_a_x;
    assign va[1] = vertex_a_y;
    assign va[2] = vertex_a_z;
    assign vb[0] = vertex_b_x;
    assign vb[1] = vertex_b_y;
    assign vb[2] = vertex_b_z;
    assign vc[0] = vertex_c_x;
    assign vc[1] = vertex_c_y;
    assign vc[2] = vertex_c_z;
    assign vq[0] = center_x;
    assign vq[1] = center_y;
    assign vq[2] = center_z;

    stc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk    (clk),
        .en     (adv),
        .va     (va),
        .vb     (vb),
        .vc     (vc),
        .vq     (vq),
        .n_out  (n_s2),
        .cr_out (cr_s2),
        .t_out  (t_s2),
        .dd_out (dd_s2),
        .ww_out (ww_s2),
        .qa_out (qa_s2)
    );

    // stages 3-5: wide products
    logic signed [2*XW-1:0]      tri_p [3][3];
    logic signed [2*XW-1:0]      nn_p [3];
    logic signed [XW+DW-1:0]     pd_p [3];
    logic signed [2*DTW-1:0]     wwdd_p [3];
    logic signed [2*DTW-1:0]     tt_p [3];
    logic signed [R2SW+DTW-1:0]  r2dd_p [3];
    stc_pkg::seg_flags_t         flags_next [3];
    stc_pkg::seg_flags_t         flags_s5 [3];

    // endpoint decisions ride alongside the products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            flags_next[k].le0  = t_s2[k][DTW-1] || (t_s2[k] == '0);
            flags_next[k].gedd = t_s2[k] >= dd_s2[k];
            flags_next[k].hs   = FW'(ww_s2[k]) <= FW'(r2s);
            // end vertex of edge k is the start vertex of the next edge
            flags_next[k].he   = FW'(ww_s2[(k == 2) ? 0 : k + 1]) <= FW'(r2s);
        end
    end

    genvar gk;
    genvar gi;
    generate
        for (gk = 0; gk < 3; gk++)
        begin : g_edge
            for (gi = 0; gi < 3; gi++)
            begin : g_comp
                stc_mul #(.AW(XW), .BW(XW)) u_tri (
                    .clk (clk), .en (adv),
                    .a (n_s2[gi]), .b (cr_s2[gk][gi]), .p (tri_p[gk][gi])
                );
            end

            stc_mul #(.AW(XW), .BW(XW)) u_nn (
                .clk (clk), .en (adv), .a (n_s2[gk]), .b (n_s2[gk]), .p (nn_p[gk])
            );
            stc_mul #(.AW(XW), .BW(DW)) u_pd (
                .clk (clk), .en (adv), .a (n_s2[gk]), .b (qa_s2[gk]), .p (pd_p[gk])
            );
            stc_mul #(.AW(DTW), .BW(DTW)) u_wwdd (
                .clk (clk), .en (adv), .a (ww_s2[gk]), .b (dd_s2[gk]), .p (wwdd_p[gk])
            );
            stc_mul #(.AW(DTW), .BW(DTW)) u_tt (
                .clk (clk), .en (adv), .a (t_s2[gk]), .b (t_s2[gk]), .p (tt_p[gk])
            );
            stc_mul #(.AW(R2SW), .BW(DTW)) u_r2dd (
                .clk (clk), .en (adv), .a (r2s), .b (dd_s2[gk]), .p (r2dd_p[gk])
            );

            stc_delay #(
                .W ($bits(stc_pkg::seg_flags_t)),
                .N (3)
            ) u_flags (
                .clk (clk),
                .en  (adv),
                .d   (flags_next[gk]),
                .q   (flags_s5[gk])
            );
        end
    endgenerate

    // stage 6: triple products, inside test, segment tests
    logic signed [TW-1:0]  tri_sum [3];
    logic signed [TW-1:0]  nn_next;
    logic signed [PDW-1:0] pd_next;
    logic                  inside_next;
    logic                  seg_next;
    logic signed [TW-1:0]  nn6_reg;
    logic signed [PDW-1:0] pd6_reg;
    logic                  inside6_reg;
    logic                  seg6_reg;

    always_comb
    begin
        logic mid;
        seg_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            tri_sum[k] = TW'(tri_p[k][0]) + TW'(tri_p[k][1]) + TW'(tri_p[k][2]);
            mid = (SW'(wwdd_p[k]) - SW'(tt_p[k])) <= SW'(r2dd_p[k]);
            if (flags_s5[k].le0)
                seg_next = seg_next | flags_s5[k].hs;
            else if (flags_s5[k].gedd)
                seg_next = seg_next | flags_s5[k].he;
            else
                seg_next = seg_next | mid;
        end
        nn_next = TW'(nn_p[0]) + TW'(nn_p[1]) + TW'(nn_p[2]);
        pd_next = PDW'(pd_p[0]) + PDW'(pd_p[1]) + PDW'(pd_p[2]);
        inside_next = (nn_next != '0) && !tri_sum[0][TW-1] && !tri_sum[1][TW-1]
                      && !tri_sum[2][TW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nn6_reg     <= nn_next;
            pd6_reg     <= pd_next;
            inside6_reg <= inside_next;
            seg6_reg    <= seg_next;
        end
    end

    // stages 7-9: plane distance squared against r^2 |n|^2
    logic signed [2*PDW-1:0]    pd2_p;
    logic signed [R2SW+TW-1:0]  r2nn_p;
    logic [1:0]                 sel_s9;

    stc_mul #(.AW(PDW), .BW(PDW)) u_pd2 (
        .clk (clk), .en (adv), .a (pd6_reg), .b (pd6_reg), .p (pd2_p)
    );
    stc_mul #(.AW(R2SW), .BW(TW)) u_r2nn (
        .clk (clk), .en (adv), .a (r2s), .b (nn6_reg), .p (r2nn_p)
    );
    stc_delay #(
        .W (2),
        .N (3)
    ) u_sel (
        .clk (clk),
        .en  (adv),
        .d   ({inside6_reg, seg6_reg}),
        .q   (sel_s9)
    );

    // stage 10: final decision
    stc_pkg::result_t res10_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res10_reg.inside_prism <= sel_s9[1];
            res10_reg.collides     <= sel_s9[1] ? (CMPW'(pd2_p) <= CMPW'(r2nn_p))
                                                : sel_s9[0];
        end
    end

    // two-entry output buffer
    stc_pkg::result_t e0_reg;
    stc_pkg::result_t e1_reg;
    stc_pkg::result_t e0_next;
    stc_pkg::result_t e1_next;

    always_comb
    begin
        count_next = count_reg;
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    e0_next = res10_reg;
                else
                    e1_next = res10_reg;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                e0_next    = e1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    e0_next = res10_reg;
                end
                else
                begin
                    e0_next = e1_reg;
                    e1_next = res10_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign out_valid    = (count_reg != 2'd0);
    assign collides     = e0_reg.collides;
    assign inside_prism = e0_reg.inside_prism;

`ifndef SYNTHESIS
    // buffer never overfills
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // input is held off only when the buffer is full and not draining
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (count_reg == 2'd2) && !pop)
        else $error("input stalled with room in output buffer");

    // a held pipeline keeps its valid bits
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("valid bits moved while pipeline held");

    // a pushed result always lands in the buffer
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg != 2'd0))
        else $error("result lost on push");
`endif

endmodule

`default_nettype wire

/* tb/tb_sphere_triangle_collision_top.sv */
`default_nettype none

module tb_sphere_triangle_collision_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [255:0] wide_t;
    typedef wide_t vec_t [3];

    // Exact-arithmetic contact predictor plus the queue of expected flags
    class collision_scoreboard;
        stc_pkg::result_t expected_flags[$];
        int errors;
        logic [30:0] radius;

        function new();
            errors = 0;
            radius = '0;
        endfunction

        function vec_t diff3(coord_t p [3], coord_t q [3]);
            vec_t r;
            for (int i = 0; i < 3; i++)
            begin
                r[i] = wide_t'(p[i]) - wide_t'(q[i]);
            end
            return r;
        endfunction

        function wide_t dot3(vec_t a, vec_t b);
            return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        endfunction

        function vec_t cross3(vec_t u, vec_t v);
            vec_t r;
            r[0] = u[1] * v[2] - u[2] * v[1];
            r[1] = u[2] * v[0] - u[0] * v[2];
            r[2] = u[0] * v[1] - u[1] * v[0];
            return r;
        endfunction

        // w = Q - start, d = end - start, we = Q - end
        function bit segment_reach(vec_t w, vec_t d, vec_t we, wide_t r2);
            wide_t t;
            wide_t dd;
            t = dot3(w, d);
            if (t <= 0)
                return dot3(w, w) <= r2;
            dd = dot3(d, d);
            if (t >= dd)
                return dot3(we, we) <= r2;
            return dot3(w, w) * dd - t * t <= r2 * dd;
        endfunction

        function void note_triangle(coord_t co [12]);
            coord_t a [3];
            coord_t b [3];
            coord_t c [3];
            coord_t q [3];
            vec_t ab, ac, bc, ca, qa, qb, qc, n;
            wide_t nn, r2, pd;
            stc_pkg::result_t res;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = co[i];
                b[i] = co[3 + i];
                c[i] = co[6 + i];
                q[i] = co[9 + i];
            end
            ab = diff3(b, a);
            ac = diff3(c, a);
            bc = diff3(c, b);
            ca = diff3(a, c);
            qa = diff3(q, a);
            qb = diff3(q, b);
            qc = diff3(q, c);
            n  = cross3(ab, ac);
            nn = dot3(n, n);
            r2 = wide_t'(radius) * wide_t'(radius);
            res.inside_prism = nn != 0 && dot3(n, cross3(ab, qa)) >= 0
                && dot3(n, cross3(bc, qb)) >= 0 && dot3(n, cross3(ca, qc)) >= 0;
            if (res.inside_prism)
            begin
                pd = dot3(n, qa);
                res.collides = pd * pd <= r2 * nn;
            end
            else
            begin
                res.collides = segment_reach(qa, ab, qb, r2)
                    || segment_reach(qb, bc, qc, r2) || segment_reach(qc, ca, qa, r2);
            end
            expected_flags.push_back(res);
        endfunction

        function void check_result(logic col, logic ins);
            stc_pkg::result_t exp_res;
            if (expected_flags.size() == 0)
            begin
                $display("%0t: unexpected result collides=%b inside_prism=%b", $time, col, ins);
                errors++;
                return;
            end
            exp_res = expected_flags.pop_front();
            if (col !== exp_res.collides)
            begin
                $display("%0t: collides expected %b actual %b", $time, exp_res.collides, col);
                errors++;
            end
            if (ins !== exp_res.inside_prism)
            begin
                $display("%0t: inside_prism expected %b actual %b", $time,
                         exp_res.inside_prism, ins);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [30:0] sphere_radius = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    coord_t vertex_a_x = '0, vertex_a_y = '0, vertex_a_z = '0;
    coord_t vertex_b_x = '0, vertex_b_y = '0, vertex_b_z = '0;
    coord_t vertex_c_x = '0, vertex_c_y = '0, vertex_c_z = '0;
    coord_t center_x = '0, center_y = '0, center_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic collides;
    logic inside_prism;

    collision_scoreboard sb = new();
    bit calm = 1'b0;

    sphere_triangle_collision_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .sphere_radius(sphere_radius),
        .in_valid(in_valid), .in_stall(in_stall),
        .vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y), .vertex_a_z(vertex_a_z),
        .vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y), .vertex_b_z(vertex_b_z),
        .vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y), .vertex_c_z(vertex_c_z),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .collides(collides), .inside_prism(inside_prism)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // input transfer monitor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_triangle('{vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                               vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                               center_x, center_y, center_z});
    end

    // result transfer checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(collides, inside_prism);
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= !calm && $urandom_range(99) < 9;
    end

    initial
    begin
        #(12ns * 300000);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_triangle(coord_t co [12]);
        if (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        vertex_a_x <= co[0];
        vertex_a_y <= co[1];
        vertex_a_z <= co[2];
        vertex_b_x <= co[3];
        vertex_b_y <= co[4];
        vertex_b_z <= co[5];
        vertex_c_x <= co[6];
        vertex_c_y <= co[7];
        vertex_c_z <= co[8];
        center_x   <= co[9];
        center_y   <= co[10];
        center_z   <= co[11];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_flags.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // radius is written only with the pipe empty
    task automatic write_radius(logic [30:0] r);
        drain();
        cfg_valid     <= 1'b1;
        sphere_radius <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.radius = r;
    endtask

    // random triangle near a random origin; center mostly close by
    task automatic send_random(int unsigned span);
        coord_t co [12];
        coord_t origin [3];
        if ($urandom_range(9) == 0)
        begin
            for (int i = 0; i < 12; i++)
                co[i] = $urandom;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
                origin[k] = $urandom_range(0, 1 << 20) - (1 << 19);
            for (int i = 0; i < 12; i++)
                co[i] = origin[i % 3] + $signed($urandom_range(0, 2 * span)) - $signed(span);
            // sometimes put the center exactly on a vertex or make an edge collapse
            case ($urandom_range(9))
                0: for (int k = 0; k < 3; k++) co[9 + k] = co[k];
                1: for (int k = 0; k < 3; k++) co[3 + k] = co[k];
                default: ;
            endcase
        end
        send_triangle(co);
    endtask

    localparam coord_t CMIN = 32'sh8000_0000;
    localparam coord_t CMAX = 32'sh7fff_ffff;
    localparam coord_t ONE  = 32'sh0001_0000;

    initial
    begin
        logic [30:0] radii [5];
        int unsigned span;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero radius: contact only with center on the triangle
        write_radius('0);
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 4, ONE / 4, 0});
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 4, ONE / 4, 1});
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 2, 0, 0});
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 2, ONE / 2, 0});
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0});
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, -1, -1, 0});
        // collinear triangle, center on the segment
        send_triangle('{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE});
        // all vertices coincident, center at the point
        send_triangle('{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});

        write_radius(31'(ONE));
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 4, ONE / 4, ONE});
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 4, ONE / 4, ONE + 1});
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 4, ONE / 4, -ONE});
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, 0, 0});
        send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE - 1, 0, 0});
        send_triangle('{0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE / 2, ONE, 0});
        send_triangle('{0, 0, 0, 0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0});
        send_triangle('{0, 0, 0, 0, ONE, 0, ONE, 0, 0, ONE / 4, ONE / 4, ONE / 2});

        // largest radius and extreme coordinates
        write_radius('1);
        send_triangle('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX});
        send_triangle('{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX});
        send_triangle('{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN});
        send_triangle('{CMIN, 0, CMAX, CMAX, 0, CMIN, 0, CMIN, 0, CMAX, CMAX, CMIN});
        send_triangle('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});

        // random phases at varied radii; one phase runs without idling
        radii = '{31'd0, 31'h7fff_ffff, 31'(ONE), 31'($urandom_range(1, 1 << 20)), 31'($urandom)};
        for (int p = 0; p < 6; p++)
        begin
            write_radius(p < 5 ? radii[p] : 31'($urandom_range(1 << 12, 1 << 18)));
            calm = (p == 3);
            for (int n = 0; n < 100; n++)
            begin
                span = 1 << $urandom_range(4, 20);
                send_random(span);
            end
        end
        calm = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
